// ===== rtl/epw_pkg.sv =====
// Shared constants, item codes and helper functions for the Euler path walker.
// No dependencies.
package epw_pkg;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int ROW_W    = 32;
    localparam int VTX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int KIND_W   = 2;
    localparam int IN_DW    = 40;   // row_index + row_bits, padded to bytes
    localparam int OUT_DW   = 8;    // vertex, padded to bytes
    localparam int OUT_UW   = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

    typedef logic [ROW_W-1:0] t_row;
    typedef logic [VTX_W-1:0] t_vtx;

    // index of the lowest set bit (0 when none)
    function automatic t_vtx lowest_bit(input t_row x);
        t_vtx r;
        r = '0;
        for (int k = ROW_W - 1; k >= 0; k--) begin
            if (x[k]) r = VTX_W'(k);
        end
        return r;
    endfunction

endpackage

// ===== rtl/euler_path_walker_unit.sv =====
// Euler path walker top level: adjacency memory plus the walk/search sequencer.
// Depends on epw_pkg.
//
// Input stream beats carry a kind in tuser: load a matrix row, restart the
// walk, or advance one edge. Loads produce no result; restart and advance
// each produce one output beat (vertex, walk_over, edges_left).
// Items are handled one at a time; o_s_tready is high only while the
// sequencer is idle. A load writes its row. A restart reads rows in order,
// up to vertex_count (clamped to 2..DEPTH), until one of odd degree. An
// advance reads the current row: with no edges it scans the rows for edges
// left and ends the walk; with two or more neighbors it runs, per candidate,
// a setup step and two reachability searches; then it removes the chosen
// edge from both rows. All rows come from one single-port read /
// single-port write memory with a registered read. The finished result
// sits in an output register; if the receiver stalls the sequencer holds
// its last result state until the register frees. Reset (synchronous,
// active low) clears the sequencer, the current vertex and vertex_count
// (to 2); matrix rows are undefined until loaded. The user must write
// vertex_count by i_cfg_wen only while idle; the block does not enforce it.
module euler_path_walker_unit #(
    parameter int MAX_VERTICES = epw_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [epw_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [4:0] row_index, [36:5] row_bits, [39:37] zero
    input  logic [epw_pkg::IN_DW-1:0]   i_s_tdata,
    // [1:0] kind
    input  logic [epw_pkg::KIND_W-1:0]  i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [4:0] vertex, [7:5] zero
    output logic [epw_pkg::OUT_DW-1:0]  o_m_tdata,
    // [0] walk_over, [1] edges_left
    output logic [epw_pkg::OUT_UW-1:0]  o_m_tuser
);
    import epw_pkg::*;

    localparam int DEPTH = (MAX_VERTICES > ROW_W) ? ROW_W : MAX_VERTICES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ODD_RD   = 4'd1;
    localparam logic [3:0] S_ODD_CHK  = 4'd2;
    localparam logic [3:0] S_CUR_RD   = 4'd3;
    localparam logic [3:0] S_CUR_CHK  = 4'd4;
    localparam logic [3:0] S_LEFT_RD  = 4'd5;
    localparam logic [3:0] S_LEFT_CHK = 4'd6;
    localparam logic [3:0] S_CAND     = 4'd7;
    localparam logic [3:0] S_SRCH     = 4'd8;
    localparam logic [3:0] S_SRCH_CHK = 4'd9;
    localparam logic [3:0] S_RM0_RD   = 4'd10;
    localparam logic [3:0] S_RM0_WR   = 4'd11;
    localparam logic [3:0] S_RM1_RD   = 4'd12;
    localparam logic [3:0] S_RM1_WR   = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    t_row mem [DEPTH];
    t_row r_rdata;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_vcount;
    t_vtx             r_cur, n_cur;
    t_vtx             r_i, n_i;
    t_vtx             r_chosen, n_chosen;
    t_vtx             r_u, n_u;
    t_row             r_cand, n_cand;
    t_row             r_reached, n_reached;
    t_row             r_visited, n_visited;
    t_row             r_mask_a, n_mask_a;
    logic             r_pass, n_pass;
    logic             r_left, n_left;
    t_vtx             r_res_vtx, n_res_vtx;
    logic             r_res_over, n_res_over;
    logic             r_res_left, n_res_left;
    logic             r_ovalid, n_ovalid;
    logic [OUT_DW-1:0] r_odata, n_odata;
    logic [OUT_UW-1:0] r_ouser, n_ouser;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    t_row             mem_wdata;

    logic [CNT_W-1:0] span;
    t_row             smask, row_m, pending, srch_row;
    logic             accept;
    t_vtx             in_idx;

    always_comb begin
        span = r_vcount;
        if (span < CNT_W'(2)) span = CNT_W'(2);
        if (span > CNT_W'(DEPTH)) span = CNT_W'(DEPTH);
    end
    assign smask   = {ROW_W{1'b1}} >> (CNT_W'(ROW_W) - span);
    assign row_m   = r_rdata & smask;
    assign pending = r_reached & ~r_visited;
    assign accept  = i_s_tvalid && o_s_tready;
    assign in_idx  = i_s_tdata[VTX_W-1:0];

    // second search pass sees the tested edge removed in both rows
    always_comb begin
        srch_row = row_m;
        if (r_pass) begin
            if (r_u == r_cur)    srch_row[r_chosen] = 1'b0;
            if (r_u == r_chosen) srch_row[r_cur]    = 1'b0;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cur      = r_cur;
        n_i        = r_i;
        n_chosen   = r_chosen;
        n_u        = r_u;
        n_cand     = r_cand;
        n_reached  = r_reached;
        n_visited  = r_visited;
        n_mask_a   = r_mask_a;
        n_pass     = r_pass;
        n_left     = r_left;
        n_res_vtx  = r_res_vtx;
        n_res_over = r_res_over;
        n_res_left = r_res_left;
        n_ovalid   = r_ovalid;
        n_odata    = r_odata;
        n_ouser    = r_ouser;
        mem_we     = 1'b0;
        mem_waddr  = AW'(in_idx);
        mem_wdata  = i_s_tdata[VTX_W +: ROW_W];
        mem_raddr  = AW'(r_cur);

        if (o_m_tvalid && i_m_tready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_s_tuser)
                        KIND_LOAD: begin
                            mem_we = (32'(in_idx) < 32'(MAX_VERTICES));
                        end
                        KIND_RESTART: begin
                            n_i     = '0;
                            n_state = S_ODD_RD;
                        end
                        KIND_ADVANCE: n_state = S_CUR_RD;
                        default: ;
                    endcase
                end
            end
            S_ODD_RD: begin
                mem_raddr = AW'(r_i);
                n_state   = S_ODD_CHK;
            end
            S_ODD_CHK: begin
                n_res_over = 1'b0;
                n_res_left = 1'b0;
                if (^row_m) begin
                    n_cur     = r_i;
                    n_res_vtx = r_i;
                    n_state   = S_OUT;
                end else if ({1'b0, r_i} == span - CNT_W'(1)) begin
                    n_cur     = '0;
                    n_res_vtx = '0;
                    n_state   = S_OUT;
                end else begin
                    n_i     = r_i + VTX_W'(1);
                    n_state = S_ODD_RD;
                end
            end
            S_CUR_RD: begin
                mem_raddr = AW'(r_cur);
                n_state   = S_CUR_CHK;
            end
            S_CUR_CHK: begin
                if (row_m == '0) begin
                    n_i     = '0;
                    n_left  = 1'b0;
                    n_state = S_LEFT_RD;
                end else if ((row_m & (row_m - ROW_W'(1))) == '0) begin
                    n_chosen = lowest_bit(row_m);
                    n_state  = S_RM0_RD;
                end else begin
                    n_cand  = row_m;
                    n_state = S_CAND;
                end
            end
            S_LEFT_RD: begin
                mem_raddr = AW'(r_i);
                n_state   = S_LEFT_CHK;
            end
            S_LEFT_CHK: begin
                // any edge on or above the diagonal
                if ((row_m >> r_i) != '0) n_left = 1'b1;
                if ({1'b0, r_i} == span - CNT_W'(1)) begin
                    n_res_vtx  = r_cur;
                    n_res_over = 1'b1;
                    n_res_left = n_left;
                    n_state    = S_OUT;
                end else begin
                    n_i     = r_i + VTX_W'(1);
                    n_state = S_LEFT_RD;
                end
            end
            S_CAND: begin
                n_chosen  = lowest_bit(r_cand);
                n_cand    = r_cand & (r_cand - ROW_W'(1));
                n_pass    = 1'b0;
                n_reached = ROW_W'(1) << lowest_bit(r_cand);
                n_visited = '0;
                n_state   = S_SRCH;
            end
            S_SRCH: begin
                if (pending == '0) begin
                    if (!r_pass) begin
                        n_mask_a  = r_reached;
                        n_pass    = 1'b1;
                        n_reached = ROW_W'(1) << r_chosen;
                        n_visited = '0;
                    end else if (r_reached == r_mask_a || r_cand == '0) begin
                        // not a bridge, or last candidate taken anyway
                        n_state = S_RM0_RD;
                    end else begin
                        n_state = S_CAND;
                    end
                end else begin
                    n_u       = lowest_bit(pending);
                    n_visited = r_visited | (ROW_W'(1) << lowest_bit(pending));
                    mem_raddr = AW'(lowest_bit(pending));
                    n_state   = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK: begin
                n_reached = r_reached | srch_row;
                n_state   = S_SRCH;
            end
            S_RM0_RD: begin
                mem_raddr = AW'(r_cur);
                n_state   = S_RM0_WR;
            end
            S_RM0_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cur);
                mem_wdata = r_rdata & ~(ROW_W'(1) << r_chosen);
                n_state   = S_RM1_RD;
            end
            S_RM1_RD: begin
                mem_raddr = AW'(r_chosen);
                n_state   = S_RM1_WR;
            end
            S_RM1_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(r_chosen);
                mem_wdata  = r_rdata & ~(ROW_W'(1) << r_cur);
                n_cur      = r_chosen;
                n_res_vtx  = r_chosen;
                n_res_over = 1'b0;
                n_res_left = 1'b0;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = OUT_DW'(r_res_vtx);
                    n_ouser  = {r_res_left, r_res_over};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= CNT_W'(2);
            r_cur    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) r_vcount <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_chosen   <= n_chosen;
        r_u        <= n_u;
        r_cand     <= n_cand;
        r_reached  <= n_reached;
        r_visited  <= n_visited;
        r_mask_a   <= n_mask_a;
        r_pass     <= n_pass;
        r_left     <= n_left;
        r_res_vtx  <= n_res_vtx;
        r_res_over <= n_res_over;
        r_res_left <= n_res_left;
        r_odata    <= n_odata;
        r_ouser    <= n_ouser;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule
